// File: rtl/mvpm_pkg.sv
// shared types and constants for the multi-voice pcm mixer
package mvpm_pkg;

  // input item function codes
  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_STOP  = 2'd2,
    FUNC_TICK  = 2'd3
  } func_t;

  // start result status codes
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_BUSY  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  // result kind codes
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_FINAL,
    ST_DONE
  } state_t;

  // fixed field widths
  localparam int SAMPLE_W = 8;
  localparam int ADDR_IN_W = 16;
  localparam int LEN_W = 16;
  localparam int GAIN_W = 12;
  localparam int MAG_W = 8;
  localparam int PROD_W = MAG_W + GAIN_W;

  // sample constants
  localparam logic [SAMPLE_W-1:0] SILENCE = 8'd128;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 8'd255;

endpackage

// File: rtl/mvpm_sample_ram.sv
// single-port-write, single-port-read sample memory with registered read data
module mvpm_sample_ram #(
  parameter int ADDR_BITS = 16
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [ADDR_BITS-1:0]          wr_addr,
  input  logic [mvpm_pkg::SAMPLE_W-1:0] wr_data,
  input  logic                          rd_en,
  input  logic [ADDR_BITS-1:0]          rd_addr,
  output logic [mvpm_pkg::SAMPLE_W-1:0] rd_data
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [mvpm_pkg::SAMPLE_W-1:0] mem [DEPTH];
  logic [mvpm_pkg::SAMPLE_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/multi_voice_pcm_mixer_core.sv
// multi-voice pcm mixer top: voice table and a tick sequencer over one shared multiplier
// load and stop items give no result and leave the sequencer idle; in_stall stays low for them
// a start item goes to the done state and is answered from the result register once that is free
// a tick walks the voices: read and mul states per active voice, read per idle voice, then final and done
// a start or tick holds in done while an earlier result is stalled, then returns to idle
// rst_n (synchronous, active low) clears the voices and handshake state, not the samples
module multi_voice_pcm_mixer_core #(
  parameter int NUM_VOICES       = 16,
  parameter int SAMPLE_ADDR_BITS = 16,
  parameter int GAIN_FRAC_BITS   = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_func,
  input  logic [mvpm_pkg::ADDR_IN_W-1:0] in_mem_addr,
  input  logic [mvpm_pkg::SAMPLE_W-1:0]  in_mem_data,
  input  logic [mvpm_pkg::ADDR_IN_W-1:0] in_sound_base,
  input  logic [mvpm_pkg::LEN_W-1:0]     in_sound_length,
  input  logic [mvpm_pkg::GAIN_W-1:0]    in_volume,
  input  logic                           in_looping,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_result_kind,
  output logic [mvpm_pkg::SAMPLE_W-1:0]  out_out_sample,
  output logic [1:0]                     out_start_status,
  output logic [3:0]                     out_voice_index
);

  localparam int VIDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int ACC_W  = mvpm_pkg::PROD_W + VIDX_W + 2;
  localparam int SUM_W  = (SAMPLE_ADDR_BITS > mvpm_pkg::ADDR_IN_W + 1) ?
                          SAMPLE_ADDR_BITS : mvpm_pkg::ADDR_IN_W + 1;
  localparam int WA_W   = (SAMPLE_ADDR_BITS > mvpm_pkg::ADDR_IN_W) ?
                          SAMPLE_ADDR_BITS : mvpm_pkg::ADDR_IN_W;
  localparam logic [VIDX_W-1:0] LAST_VOICE = VIDX_W'(NUM_VOICES - 1);

  // sequencer state
  mvpm_pkg::state_t state_r, state_nxt;
  logic [VIDX_W-1:0] idx_r;

  // voice table
  logic                          voice_active_r [NUM_VOICES];
  logic [mvpm_pkg::ADDR_IN_W-1:0] voice_base_r   [NUM_VOICES];
  logic [mvpm_pkg::LEN_W-1:0]    voice_length_r [NUM_VOICES];
  logic [mvpm_pkg::LEN_W-1:0]    voice_pos_r    [NUM_VOICES];
  logic [mvpm_pkg::GAIN_W-1:0]   voice_gain_r   [NUM_VOICES];
  logic                          voice_loop_r   [NUM_VOICES];

  // mixing datapath
  logic [mvpm_pkg::PROD_W-1:0]   prod_mag_r;
  logic                          prod_neg_r;
  logic                          prod_valid_r;
  logic signed [ACC_W-1:0]       acc_r;

  // pending result
  logic                          res_kind_r;
  logic [1:0]                    res_status_r;
  logic [VIDX_W-1:0]             res_index_r;

  // result register
  logic                          out_valid_r;
  logic                          out_kind_r;
  logic [mvpm_pkg::SAMPLE_W-1:0] out_sample_r;
  logic [1:0]                    out_status_r;
  logic [3:0]                    out_index_r;

  // handshake and control
  logic                          in_accept;
  logic                          out_load;
  logic                          ram_re;
  mvpm_pkg::func_t               func;

  // sample memory
  logic                          ram_we;
  logic [WA_W-1:0]               wr_addr_ext;
  logic [SUM_W-1:0]              rd_addr_sum;
  logic [mvpm_pkg::SAMPLE_W-1:0] ram_rdata;

  // per-voice helpers
  logic                          free_found;
  logic [VIDX_W-1:0]             free_idx;
  logic [mvpm_pkg::MAG_W-1:0]    mag;
  logic                          mag_neg;
  logic [mvpm_pkg::PROD_W-1:0]   mult;
  logic [mvpm_pkg::LEN_W:0]      pos_inc;
  logic signed [ACC_W-1:0]       term;
  logic signed [ACC_W-1:0]       acc_sum;
  logic signed [ACC_W-1:0]       biased;
  logic [mvpm_pkg::SAMPLE_W-1:0] sat_sample;

  assign func      = mvpm_pkg::func_t'(in_func);
  assign in_accept = in_valid && !in_stall;

  // outputs of the sequencer
  always_comb begin
    in_stall = (state_r != mvpm_pkg::ST_IDLE);
    ram_re   = (state_r == mvpm_pkg::ST_READ) && voice_active_r[idx_r];
    out_load = (state_r == mvpm_pkg::ST_DONE) && (!out_valid_r || !out_stall);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mvpm_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (func == mvpm_pkg::FUNC_TICK) begin
            state_nxt = mvpm_pkg::ST_READ;
          end else if (func == mvpm_pkg::FUNC_START) begin
            state_nxt = mvpm_pkg::ST_DONE;
          end
        end
      end
      mvpm_pkg::ST_READ: begin
        if (voice_active_r[idx_r]) begin
          state_nxt = mvpm_pkg::ST_MUL;
        end else if (idx_r == LAST_VOICE) begin
          state_nxt = mvpm_pkg::ST_FINAL;
        end
      end
      mvpm_pkg::ST_MUL: begin
        state_nxt = (idx_r == LAST_VOICE) ? mvpm_pkg::ST_FINAL : mvpm_pkg::ST_READ;
      end
      mvpm_pkg::ST_FINAL: begin
        state_nxt = mvpm_pkg::ST_DONE;
      end
      mvpm_pkg::ST_DONE: begin
        if (out_load) begin
          state_nxt = mvpm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mvpm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mvpm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sample memory ports
  assign ram_we      = in_accept && (func == mvpm_pkg::FUNC_LOAD);
  assign wr_addr_ext = WA_W'(in_mem_addr);
  assign rd_addr_sum = SUM_W'(voice_base_r[idx_r]) + SUM_W'(voice_pos_r[idx_r]);

  mvpm_sample_ram #(
    .ADDR_BITS (SAMPLE_ADDR_BITS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wr_addr_ext[SAMPLE_ADDR_BITS-1:0]),
    .wr_data (in_mem_data),
    .rd_en   (ram_re),
    .rd_addr (rd_addr_sum[SAMPLE_ADDR_BITS-1:0]),
    .rd_data (ram_rdata)
  );

  // lowest inactive slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int v = NUM_VOICES - 1; v >= 0; v--) begin
      if (!voice_active_r[v]) begin
        free_found = 1'b1;
        free_idx   = VIDX_W'(v);
      end
    end
  end

  // signed magnitude of the sample and the scaled product
  always_comb begin
    mag_neg = (ram_rdata < mvpm_pkg::SILENCE);
    mag     = mag_neg ? (mvpm_pkg::SILENCE - ram_rdata) : (ram_rdata - mvpm_pkg::SILENCE);
    mult    = mvpm_pkg::PROD_W'(mag) * mvpm_pkg::PROD_W'(voice_gain_r[idx_r]);
    pos_inc = {1'b0, voice_pos_r[idx_r]} + {{mvpm_pkg::LEN_W{1'b0}}, 1'b1};
  end

  // accumulate the pending product
  always_comb begin
    term = $signed(ACC_W'(prod_mag_r));
    if (prod_neg_r) begin
      term = -term;
    end
    acc_sum = prod_valid_r ? (acc_r + term) : acc_r;
  end

  // bias and saturate the frame sum
  always_comb begin
    biased = acc_r + $signed(ACC_W'(mvpm_pkg::SILENCE));
    if (biased < 0) begin
      sat_sample = '0;
    end else if (biased > $signed(ACC_W'(mvpm_pkg::SAMPLE_MAX))) begin
      sat_sample = mvpm_pkg::SAMPLE_MAX;
    end else begin
      sat_sample = biased[mvpm_pkg::SAMPLE_W-1:0];
    end
  end

  // voice active bits: start, stop and end of sound
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int v = 0; v < NUM_VOICES; v++) begin
        voice_active_r[v] <= 1'b0;
      end
    end else begin
      if (in_accept && (func == mvpm_pkg::FUNC_STOP)) begin
        for (int v = 0; v < NUM_VOICES; v++) begin
          if (voice_base_r[v] == in_sound_base) begin
            voice_active_r[v] <= 1'b0;
          end
        end
      end else if (in_accept && (func == mvpm_pkg::FUNC_START) &&
                   (in_sound_length != '0) && free_found) begin
        voice_active_r[free_idx] <= 1'b1;
      end else if ((state_r == mvpm_pkg::ST_MUL) &&
                   (pos_inc >= {1'b0, voice_length_r[idx_r]}) && !voice_loop_r[idx_r]) begin
        voice_active_r[idx_r] <= 1'b0;
      end
    end
  end

  // voice parameters and positions
  always_ff @(posedge clk) begin
    if (in_accept && (func == mvpm_pkg::FUNC_START) &&
        (in_sound_length != '0) && free_found) begin
      voice_base_r[free_idx]   <= in_sound_base;
      voice_length_r[free_idx] <= in_sound_length;
      voice_pos_r[free_idx]    <= '0;
      voice_gain_r[free_idx]   <= in_volume;
      voice_loop_r[free_idx]   <= in_looping;
    end else if (state_r == mvpm_pkg::ST_MUL) begin
      if ((pos_inc >= {1'b0, voice_length_r[idx_r]}) && voice_loop_r[idx_r]) begin
        voice_pos_r[idx_r] <= '0;
      end else begin
        voice_pos_r[idx_r] <= pos_inc[mvpm_pkg::LEN_W-1:0];
      end
    end
  end

  // voice counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (state_r == mvpm_pkg::ST_IDLE) begin
      idx_r <= '0;
    end else if (((state_r == mvpm_pkg::ST_READ) && !voice_active_r[idx_r]) ||
                 (state_r == mvpm_pkg::ST_MUL)) begin
      if (idx_r != LAST_VOICE) begin
        idx_r <= idx_r + VIDX_W'(1);
      end
    end
  end

  // product register and frame accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
    end else if (state_r == mvpm_pkg::ST_MUL) begin
      prod_valid_r <= 1'b1;
    end else if ((state_r == mvpm_pkg::ST_READ) || (state_r == mvpm_pkg::ST_FINAL) ||
                 (state_r == mvpm_pkg::ST_IDLE)) begin
      prod_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == mvpm_pkg::ST_IDLE) begin
      acc_r <= '0;
    end else if ((state_r == mvpm_pkg::ST_READ) || (state_r == mvpm_pkg::ST_FINAL)) begin
      acc_r <= acc_sum;
    end
    if (state_r == mvpm_pkg::ST_MUL) begin
      prod_mag_r <= mult >> GAIN_FRAC_BITS;
      prod_neg_r <= mag_neg;
    end
  end

  // pending result fields, set when the item is taken
  always_ff @(posedge clk) begin
    if (in_accept) begin
      if (func == mvpm_pkg::FUNC_START) begin
        res_kind_r <= mvpm_pkg::KIND_STATUS;
        res_index_r <= '0;
        if (in_sound_length == '0) begin
          res_status_r <= mvpm_pkg::STATUS_EMPTY;
        end else if (!free_found) begin
          res_status_r <= mvpm_pkg::STATUS_BUSY;
        end else begin
          res_status_r <= mvpm_pkg::STATUS_OK;
          res_index_r  <= free_idx;
        end
      end else begin
        res_kind_r   <= mvpm_pkg::KIND_SAMPLE;
        res_status_r <= mvpm_pkg::STATUS_OK;
        res_index_r  <= '0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind_r   <= res_kind_r;
      out_status_r <= res_status_r;
      out_index_r  <= 4'(res_index_r);
      out_sample_r <= (res_kind_r == mvpm_pkg::KIND_SAMPLE) ? sat_sample : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_kind_r;
  assign out_out_sample   = out_sample_r;
  assign out_start_status = out_status_r;
  assign out_voice_index  = out_index_r;

endmodule
